>>> design/dnsae_pkg.sv
// ----------------------------------------------------------------------------
// dnsae_pkg
// Shared types, parse phase codes and DNS constants for the response address
// extractor.
// ----------------------------------------------------------------------------
package dnsae_pkg;

  // parse phase codes
  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_QLABEL  = 4'd1;
  localparam logic [3:0] PH_QSKIP   = 4'd2;
  localparam logic [3:0] PH_QFOOT   = 4'd3;
  localparam logic [3:0] PH_ANAME   = 4'd4;
  localparam logic [3:0] PH_ALSKIP  = 4'd5;
  localparam logic [3:0] PH_APTR    = 4'd6;
  localparam logic [3:0] PH_AFIXED  = 4'd7;
  localparam logic [3:0] PH_AADDR   = 4'd8;
  localparam logic [3:0] PH_ARDSKIP = 4'd9;
  localparam logic [3:0] PH_DONE    = 4'd10;
  localparam logic [3:0] PH_FAIL    = 4'd11;

  // configuration register indexes
  localparam logic CFG_MAX_ADDRESSES = 1'b0;
  localparam logic CFG_EXPECTED_ID   = 1'b1;

  // result kinds
  localparam logic KIND_ADDR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [15:0] TYPE_A        = 16'd1;
  localparam logic [15:0] TYPE_AAAA     = 16'd28;
  localparam logic [15:0] RR_CLASS_INET = 16'h0001;
  localparam logic [7:0]  PTR_MASK      = 8'hc0;

  localparam logic [3:0] HDR_LAST_BYTE = 4'd11;
  localparam logic [3:0] QFOOT_LAST    = 4'd3;
  localparam logic [3:0] AFIXED_LAST   = 4'd9;
  localparam logic [3:0] V4_LAST_POS   = 4'd3;
  localparam logic [3:0] V6_LAST_POS   = 4'd15;

  typedef struct packed {
    logic       kind;
    logic [7:0] record_number;
    logic [3:0] byte_position;
    logic [7:0] addr_byte;
    logic       is_ipv6;
    logic       record_done;
    logic [7:0] address_count;
    logic       header_ok;
  } result_t;

  // phase on entry to the next answer record
  function automatic logic [3:0] start_record_phase(input logic [15:0] answers,
                                                    input logic [7:0]  accepted,
                                                    input logic [7:0]  max_addr);
    if ((answers == 16'd0) || (accepted >= max_addr)) begin
      return PH_DONE;
    end
    return PH_ANAME;
  endfunction

  // big-endian 16-bit field assembly, one byte at a time
  function automatic logic [15:0] put_word(input logic [15:0] w,
                                           input logic        odd,
                                           input logic [7:0]  b);
    if (!odd) begin
      return {b, 8'h00};
    end
    return {w[15:8], b};
  endfunction

endpackage

>>> design/dns_response_address_extractor_core.sv
// ----------------------------------------------------------------------------
// dns_response_address_extractor_core
// Parses a DNS response byte stream and emits A/AAAA address bytes plus an
// end-of-packet summary.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one packet byte per request, in_tlast on the final byte.
//   out_*  : zero, one or two results per request. out_tuser[0] = 0 for an
//            address byte, 1 for the end-of-packet summary; out_tlast marks
//            the final byte of an address.
//   cfg_*  : register writes (0 = max_addresses, 1 = expected_id), always
//            ready; write only while the block is idle.
// Latency: a result appears on out_* the cycle after its input byte.
// Throughput: one byte per cycle while in_tready is high. A final byte that also
//   carries an address byte yields two results; the block then holds off the
//   next byte until the single output port has drained the first of them.
// Reset: parser returns to the header phase, output buffer empties,
//   max_addresses and expected_id go to 1.
// Stall: results wait in the two-entry output buffer; in_tready drops once
//   the buffer cannot take the worst case of two results from the next byte.
module dns_response_address_extractor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // packet_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] record_number, [11:8] byte_position,
                                  // [19:12] addr_byte, [27:20] address_count,
                                  // [28] header_ok, [31:29] zero
  output logic [1:0]  out_tuser,  // [0] kind, [1] is_ipv6
  output logic        out_tlast,  // record_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import dnsae_pkg::*;

  logic [7:0]  max_addr_r;
  logic [15:0] expected_id_r;

  logic [3:0]  phase_r,    phase_nxt;
  logic [3:0]  fbc_r,      fbc_nxt;
  logic [15:0] id_r,       id_nxt;
  logic [15:0] flags_r,    flags_nxt;
  logic [15:0] qleft_r,    qleft_nxt;
  logic [15:0] aleft_r,    aleft_nxt;
  logic [15:0] skip_r,     skip_nxt;
  logic [15:0] rtype_r,    rtype_nxt;
  logic [15:0] rclass_r,   rclass_nxt;
  logic [15:0] rlen_r,     rlen_nxt;
  logic [7:0]  acc_r,      acc_nxt;

  logic        in_acc;
  logic        pop;
  logic        hdr_ok;
  logic        v6;
  logic        addr_done;
  logic        sum_ok;
  logic [15:0] len_now;
  logic [15:0] aleft_dec;
  logic [15:0] skip_dec;
  logic [15:0] qleft_dec;
  logic [7:0]  acc_inc;
  logic [7:0]  b;

  logic        emit_addr;
  logic        emit_sum;
  result_t     res_addr;
  result_t     res_sum;

  // two-entry output buffer, slot0 is the head
  logic [1:0]  cnt_r;
  result_t     slot0_r;
  result_t     slot1_r;

  // accepted count as it stands after this byte, before the end-of-packet clear
  function automatic logic [7:0] acc_nxt_pre_clear(input logic [7:0] acc,
                                                   input logic [7:0] inc,
                                                   input logic       addr,
                                                   input logic       done);
    return (addr && done) ? inc : acc;
  endfunction

  assign b         = in_tdata;
  assign cfg_ready = 1'b1;
  assign pop       = out_tvalid && out_tready;
  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign hdr_ok = (id_r == expected_id_r) && flags_r[15] &&
                  (flags_r[14:11] == 4'd0) && (flags_r[3:0] == 4'd0);
  assign len_now   = {rlen_r[15:8], b};
  assign aleft_dec = aleft_r - 16'd1;
  assign skip_dec  = skip_r - 16'd1;
  assign qleft_dec = qleft_r - 16'd1;
  assign acc_inc   = acc_r + 8'd1;
  assign v6        = (rtype_r == TYPE_AAAA);
  assign addr_done = fbc_r >= (v6 ? V6_LAST_POS : V4_LAST_POS);

  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    id_nxt     = id_r;
    flags_nxt  = flags_r;
    qleft_nxt  = qleft_r;
    aleft_nxt  = aleft_r;
    skip_nxt   = skip_r;
    rtype_nxt  = rtype_r;
    rclass_nxt = rclass_r;
    rlen_nxt   = rlen_r;
    acc_nxt    = acc_r;
    emit_addr  = 1'b0;
    emit_sum   = 1'b0;
    sum_ok     = 1'b0;

    res_addr               = '0;
    res_addr.kind          = KIND_ADDR;
    res_addr.record_number = acc_r;
    res_addr.byte_position = fbc_r;
    res_addr.addr_byte     = b;
    res_addr.is_ipv6       = v6;
    res_addr.record_done   = addr_done;

    if (in_acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (!fbc_r[3]) begin
            unique case (fbc_r[2:1])
              2'd0:    id_nxt    = put_word(id_r, fbc_r[0], b);
              2'd1:    flags_nxt = put_word(flags_r, fbc_r[0], b);
              2'd2:    qleft_nxt = put_word(qleft_r, fbc_r[0], b);
              default: aleft_nxt = put_word(aleft_r, fbc_r[0], b);
            endcase
          end
          if (fbc_r >= HDR_LAST_BYTE) begin
            fbc_nxt = '0;
            if (!hdr_ok) begin
              phase_nxt = PH_FAIL;
            end else if (qleft_r == 16'd0) begin
              phase_nxt = start_record_phase(aleft_r, acc_r, max_addr_r);
            end else begin
              phase_nxt = PH_QLABEL;
            end
          end else begin
            fbc_nxt = fbc_r + 4'd1;
          end
        end
        PH_QLABEL: begin
          if (b == 8'd0) begin
            fbc_nxt   = '0;
            phase_nxt = PH_QFOOT;
          end else begin
            skip_nxt  = {8'd0, b};
            phase_nxt = PH_QSKIP;
          end
        end
        PH_QSKIP, PH_ALSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_nxt = (phase_r == PH_QSKIP) ? PH_QLABEL : PH_ANAME;
          end
        end
        PH_QFOOT: begin
          if (fbc_r >= QFOOT_LAST) begin
            fbc_nxt   = '0;
            qleft_nxt = qleft_dec;
            if (qleft_dec == 16'd0) begin
              phase_nxt = start_record_phase(aleft_r, acc_r, max_addr_r);
            end else begin
              phase_nxt = PH_QLABEL;
            end
          end else begin
            fbc_nxt = fbc_r + 4'd1;
          end
        end
        PH_ANAME: begin
          if (b == 8'd0) begin
            fbc_nxt   = '0;
            phase_nxt = PH_AFIXED;
          end else if ((b & PTR_MASK) != 8'd0) begin
            phase_nxt = PH_APTR;
          end else begin
            skip_nxt  = {8'd0, b};
            phase_nxt = PH_ALSKIP;
          end
        end
        PH_APTR: begin
          fbc_nxt   = '0;
          phase_nxt = PH_AFIXED;
        end
        PH_AFIXED: begin
          // type, class, ttl (ignored), rdlength
          if (fbc_r < 4'd2) begin
            rtype_nxt = put_word(rtype_r, fbc_r[0], b);
          end else if (fbc_r < 4'd4) begin
            rclass_nxt = put_word(rclass_r, fbc_r[0], b);
          end else if (fbc_r >= 4'd8) begin
            rlen_nxt = put_word(rlen_r, fbc_r[0], b);
          end
          if (fbc_r >= AFIXED_LAST) begin
            fbc_nxt = '0;
            if ((rclass_r == RR_CLASS_INET) &&
                (((rtype_r == TYPE_A) && (len_now == 16'd4)) ||
                 ((rtype_r == TYPE_AAAA) && (len_now == 16'd16)))) begin
              phase_nxt = PH_AADDR;
            end else if (len_now == 16'd0) begin
              aleft_nxt = aleft_dec;
              phase_nxt = start_record_phase(aleft_dec, acc_r, max_addr_r);
            end else begin
              skip_nxt  = len_now;
              phase_nxt = PH_ARDSKIP;
            end
          end else begin
            fbc_nxt = fbc_r + 4'd1;
          end
        end
        PH_AADDR: begin
          emit_addr = 1'b1;
          if (addr_done) begin
            fbc_nxt   = '0;
            acc_nxt   = acc_inc;
            aleft_nxt = aleft_dec;
            phase_nxt = start_record_phase(aleft_dec, acc_inc, max_addr_r);
          end else begin
            fbc_nxt = fbc_r + 4'd1;
          end
        end
        PH_ARDSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            aleft_nxt = aleft_dec;
            phase_nxt = start_record_phase(aleft_dec, acc_r, max_addr_r);
          end
        end
        default: begin
        end
      endcase

      if (in_tlast) begin
        emit_sum   = 1'b1;
        sum_ok     = (phase_nxt != PH_HEADER) && (phase_nxt != PH_FAIL);
        phase_nxt  = PH_HEADER;
        fbc_nxt    = '0;
        id_nxt     = '0;
        flags_nxt  = '0;
        qleft_nxt  = '0;
        aleft_nxt  = '0;
        skip_nxt   = '0;
        rtype_nxt  = '0;
        rclass_nxt = '0;
        rlen_nxt   = '0;
        acc_nxt    = '0;
      end
    end

    res_sum               = '0;
    res_sum.kind          = KIND_SUMMARY;
    res_sum.address_count = sum_ok ? acc_nxt_pre_clear(acc_r, acc_inc, emit_addr,
                                                       addr_done) : 8'd0;
    res_sum.header_ok     = sum_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_addr_r    <= 8'd1;
      expected_id_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_ADDRESSES: max_addr_r    <= cfg_data[7:0];
        default:           expected_id_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      fbc_r    <= '0;
      id_r     <= '0;
      flags_r  <= '0;
      qleft_r  <= '0;
      aleft_r  <= '0;
      skip_r   <= '0;
      rtype_r  <= '0;
      rclass_r <= '0;
      rlen_r   <= '0;
      acc_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      id_r     <= id_nxt;
      flags_r  <= flags_nxt;
      qleft_r  <= qleft_nxt;
      aleft_r  <= aleft_nxt;
      skip_r   <= skip_nxt;
      rtype_r  <= rtype_nxt;
      rclass_r <= rclass_nxt;
      rlen_r   <= rlen_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // output buffer count; a request is taken when the buffer is empty or its
  // single entry leaves in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && (emit_addr || emit_sum)) begin
      cnt_r <= (emit_addr && emit_sum) ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (emit_addr || emit_sum)) begin
      slot0_r <= emit_addr ? res_addr : res_sum;
      slot1_r <= res_sum;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {3'd0, slot0_r.header_ok, slot0_r.address_count,
                       slot0_r.addr_byte, slot0_r.byte_position,
                       slot0_r.record_number};
  assign out_tuser  = {slot0_r.is_ipv6, slot0_r.kind};
  assign out_tlast  = slot0_r.record_done;

endmodule
